/* rtl/core/lwg_pkg.sv */
// Shared constants and types for the uGIMP linear weight/gradient core.
package lwg_pkg;

  localparam int LWG_FRAC_BITS = 16;
  localparam int COORD_W       = 32;
  localparam int HALF_W        = 31;
  localparam int NODE_W        = 16;
  localparam int WEIGHT_W      = 17;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 32;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ORIGIN_X   = 2'd0,
    CFG_ORIGIN_Y   = 2'd1,
    CFG_CELL_WIDTH = 2'd2
  } cfg_reg_t;

  // Piece of the per-axis overlap integral
  typedef enum logic [1:0] {
    SEG_FAR,
    SEG_RAMP,
    SEG_FLAT,
    SEG_CORE
  } seg_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0]       weight;
    logic signed [COORD_W-1:0] grad_x;
    logic signed [COORD_W-1:0] grad_y;
    logic                      range_error;
  } result_t;

endpackage

/* rtl/core/lwg_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module lwg_div import lwg_pkg::*; #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             vld_o,
  output logic [QW-1:0]    quo_o,
  output logic [SW-1:0]    side_o
);

  localparam int IW = DW + QW;

  logic [IW-1:0] rem_src [QW];
  logic [IW-1:0] rem_nxt [QW];
  logic [IW-1:0] rem_r   [QW];
  logic [QW-1:0] quo_src [QW];
  logic [QW-1:0] quo_nxt [QW];
  logic [QW-1:0] quo_r   [QW];
  logic [DW-1:0] den_src [QW];
  logic [DW-1:0] den_r   [QW];
  logic [SW-1:0] side_r  [QW];
  logic [QW-1:0] vld_r;

  always_comb begin
    logic [IW-1:0] sub;
    rem_src[0] = num_i;
    quo_src[0] = '0;
    den_src[0] = den_i;
    for (int k = 1; k < QW; k++) begin
      rem_src[k] = rem_r[k-1];
      quo_src[k] = quo_r[k-1];
      den_src[k] = den_r[k-1];
    end
    // stage k settles quotient bit QW-1-k
    for (int k = 0; k < QW; k++) begin
      sub = IW'(den_src[k]) << (QW - 1 - k);
      if (rem_src[k] >= sub) begin
        rem_nxt[k] = rem_src[k] - sub;
        quo_nxt[k] = {quo_src[k][QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_src[k];
        quo_nxt[k] = {quo_src[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_src[k];
      end
      for (int k = 1; k < QW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], vld_i};
    end
  end

  assign vld_o  = vld_r[QW-1];
  assign quo_o  = quo_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule

/* rtl/core/lwg_axis.sv */
// One axis: node distance, segment select and numerators of integral and slope.
module lwg_axis import lwg_pkg::*; #(
  parameter int FRAC_BITS = LWG_FRAC_BITS,
  parameter int SW        = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_i,
  input  logic signed [COORD_W-1:0] pos_i,
  input  logic signed [COORD_W-1:0] org_i,
  input  logic [HALF_W-1:0]         w_i,
  input  logic [HALF_W-1:0]         hl_i,
  input  logic [NODE_W-1:0]         node_i,
  input  logic [SW-1:0]             side_i,
  output logic                      vld_o,
  output logic [63:0]               inum_o,
  output logic [31:0]               iden_o,
  output logic [63:0]               smag_o,
  output logic                      sneg_o,
  output logic [SW-1:0]             side_o
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_r;
  logic [SW-1:0]   side_r [NSTG];

  // stage 1
  logic [31:0] pos1_r, org1_r;
  logic [30:0] w1_r, hl1_r;
  logic [46:0] wn1_r;
  // stage 2
  logic [31:0] pos2_r;
  logic [48:0] node2_r;
  logic [30:0] w2_r, hl2_r;
  // stage 3
  logic [49:0] ad3_r;
  logic        dneg3_r;
  logic [31:0] wph3_r;
  logic [30:0] wmh3_r, w3_r, hl3_r;
  // stage 4
  seg_t        seg4_r;
  logic [31:0] a4_r, ad4_r;
  logic [30:0] wma4_r, w4_r, hl4_r;
  logic        dneg4_r;
  // stage 5
  seg_t        seg5_r;
  logic [63:0] aa5_r, tw5_r, hw5_r, hh5_r, dd5_r;
  logic [32:0] smb5_r;
  logic [30:0] w5_r;
  logic        dneg5_r;

  logic [49:0] d3;
  seg_t        seg4;
  logic [63:0] inum6;

  always_comb begin
    d3 = {{18{pos2_r[31]}}, pos2_r} - {node2_r[48], node2_r};
  end

  always_comb begin
    priority if (ad3_r >= 50'(wph3_r)) begin
      seg4 = SEG_FAR;
    end else if (ad3_r >= 50'(wmh3_r)) begin
      seg4 = SEG_RAMP;
    end else if (ad3_r >= 50'(hl3_r)) begin
      seg4 = SEG_FLAT;
    end else begin
      seg4 = SEG_CORE;
    end
  end

  always_comb begin
    unique case (seg5_r)
      SEG_FAR:  inum6 = '0;
      SEG_RAMP: inum6 = aa5_r;
      SEG_FLAT: inum6 = tw5_r;
      SEG_CORE: inum6 = (hw5_r << 1) - hh5_r - dd5_r;
      default:  inum6 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r  <= pos_i;
      org1_r  <= org_i;
      w1_r    <= w_i;
      hl1_r   <= hl_i;
      wn1_r   <= 47'(w_i) * 47'(node_i);

      pos2_r  <= pos1_r;
      node2_r <= {{17{org1_r[31]}}, org1_r} + {2'b00, wn1_r};
      w2_r    <= w1_r;
      hl2_r   <= hl1_r;

      ad3_r   <= d3[49] ? (50'd0 - d3) : d3;
      dneg3_r <= d3[49];
      wph3_r  <= {1'b0, w2_r} + {1'b0, hl2_r};
      wmh3_r  <= w2_r - hl2_r;
      w3_r    <= w2_r;
      hl3_r   <= hl2_r;

      seg4_r  <= seg4;
      a4_r    <= wph3_r - ad3_r[31:0];
      wma4_r  <= w3_r - ad3_r[30:0];
      ad4_r   <= ad3_r[31:0];
      w4_r    <= w3_r;
      hl4_r   <= hl3_r;
      dneg4_r <= dneg3_r;

      seg5_r  <= seg4_r;
      aa5_r   <= 64'(a4_r) * 64'(a4_r);
      tw5_r   <= 64'({hl4_r, 1'b0}) * 64'(wma4_r);
      hw5_r   <= 64'(hl4_r) * 64'(w4_r);
      hh5_r   <= 64'(hl4_r) * 64'(hl4_r);
      dd5_r   <= 64'(ad4_r) * 64'(ad4_r);
      unique case (seg4_r)
        SEG_FAR:  smb5_r <= '0;
        SEG_RAMP: smb5_r <= {1'b0, a4_r};
        SEG_FLAT: smb5_r <= {1'b0, hl4_r, 1'b0};
        SEG_CORE: smb5_r <= {ad4_r, 1'b0};
        default:  smb5_r <= '0;
      endcase
      w5_r    <= w4_r;
      dneg5_r <= dneg4_r;

      inum_o  <= inum6;
      iden_o  <= (seg5_r == SEG_RAMP) ? {w5_r, 1'b0} : {1'b0, w5_r};
      smag_o  <= 64'(smb5_r) << FRAC_BITS;
      sneg_o  <= !dneg5_r;

      side_r[0] <= side_i;
      for (int k = 1; k < NSTG; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], vld_i};
    end
  end

  assign vld_o  = vld_r[NSTG-1];
  assign side_o = side_r[NSTG-1];

endmodule

/* rtl/core/ugimp_linear_weight_grad_2d_core.sv */
// Top level of the uGIMP linear weight and gradient core, 2D.
//
// Usage:
//   in_*   : one material point / grid node pair per transaction (valid/ready).
//   out_*  : one result transaction per input: weight, gradient, range_error.
//   cfg_*  : register writes (0 origin x, 1 origin y, 2 cell width); cfg_ready
//            is always high. Write only while no transaction is in flight.
// Pipeline: six front-end stages and one product stage sit around a divider
//   chain that settles one quotient bit per stage: 32 for the per-axis
//   integral and slope, FRAC_BITS+1 for the normalized integrals,
//   2*FRAC_BITS+1 for the gradients.
// Throughput: one transaction per cycle while the output buffer has room;
//   every stage is registered and a new pair may enter each cycle.
// Reset: synchronous, active low; clears all valid bits and the output
//   buffer, origins go to 0 and cell width to 1.0.
// Stall: a two-entry output buffer parts the pipeline from the receiver. When
//   it is full the whole pipeline holds and in_ready drops; nothing is lost
//   or repeated. in_ready depends only on the buffer count, not on out_ready.
// Range error (hl = 0 or 2*hl >= w): weight and gradients come out as zero.
module ugimp_linear_weight_grad_2d_core import lwg_pkg::*; #(
  parameter int FRAC_BITS = LWG_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input transactions
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic [HALF_W-1:0]         in_half_width,
  input  logic [NODE_W-1:0]         in_node_x,
  input  logic [NODE_W-1:0]         in_node_y,
  // result transactions
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [WEIGHT_W-1:0]       out_weight_value,
  output logic signed [COORD_W-1:0] out_grad_x,
  output logic signed [COORD_W-1:0] out_grad_y,
  output logic                      out_range_error,
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int QB  = 32;                 // integral / slope quotient bits
  localparam int QC  = FRAC_BITS + 1;      // normalized integral bits
  localparam int QD  = 2 * FRAC_BITS + 1;  // gradient quotient bits
  localparam int GW  = FRAC_BITS + 2;      // signed slope width
  localparam int PW  = 2 * FRAC_BITS + 4;  // signed product width
  localparam int WPW = 2 * FRAC_BITS + 2;  // weight product width
  localparam int EW  = (QD + 1 > 33) ? QD + 1 : 33;

  // configuration registers
  logic signed [COORD_W-1:0] origin_x_r, origin_y_r;
  logic [HALF_W-1:0]         cell_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      cell_width_r <= HALF_W'(1) << FRAC_BITS;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_ORIGIN_X:   origin_x_r   <= cfg_data;
        CFG_ORIGIN_Y:   origin_y_r   <= cfg_data;
        CFG_CELL_WIDTH: cell_width_r <= cfg_data[HALF_W-1:0];
        default:        ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // output buffer state; the pipeline advances while it has room
  result_t     buf_mem [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        en;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  // range check on entry: hl = 0 or 2*hl >= w
  logic err_in;
  assign err_in = (in_half_width == '0) ||
                  ({in_half_width, 1'b0} >= {1'b0, cell_width_r});

  // per-axis front end
  logic        vld_a;
  logic [63:0] inum_x, inum_y, smag_x, smag_y;
  logic [31:0] iden_x, iden_y;
  logic        sneg_x, sneg_y, err_a;
  logic [HALF_W-1:0] hl_a;

  lwg_axis #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_axis_x (
    .clk, .rst_n, .en,
    .vld_i(in_valid & en), .pos_i(in_point_x), .org_i(origin_x_r),
    .w_i(cell_width_r), .hl_i(in_half_width), .node_i(in_node_x),
    .side_i(err_in),
    .vld_o(vld_a), .inum_o(inum_x), .iden_o(iden_x), .smag_o(smag_x),
    .sneg_o(sneg_x), .side_o(err_a)
  );

  lwg_axis #(.FRAC_BITS(FRAC_BITS), .SW(HALF_W)) u_axis_y (
    .clk, .rst_n, .en,
    .vld_i(in_valid & en), .pos_i(in_point_y), .org_i(origin_y_r),
    .w_i(cell_width_r), .hl_i(in_half_width), .node_i(in_node_y),
    .side_i(in_half_width),
    .vld_o(), .inum_o(inum_y), .iden_o(iden_y), .smag_o(smag_y),
    .sneg_o(sneg_y), .side_o(hl_a)
  );

  // integrals divided by w or 2w, slopes by w
  logic          vld_b, err_b, gneg_x, gneg_y;
  logic [QB-1:0] ixq, iyq, gxq, gyq;
  logic [HALF_W-1:0] hl_b;

  lwg_div #(.DW(32), .QW(QB), .SW(1)) u_div_ix (
    .clk, .rst_n, .en, .vld_i(vld_a), .num_i(inum_x), .den_i(iden_x),
    .side_i(err_a), .vld_o(vld_b), .quo_o(ixq), .side_o(err_b)
  );
  lwg_div #(.DW(32), .QW(QB), .SW(HALF_W)) u_div_iy (
    .clk, .rst_n, .en, .vld_i(vld_a), .num_i(inum_y), .den_i(iden_y),
    .side_i(hl_a), .vld_o(), .quo_o(iyq), .side_o(hl_b)
  );
  lwg_div #(.DW(32), .QW(QB), .SW(1)) u_div_gx (
    .clk, .rst_n, .en, .vld_i(vld_a), .num_i(smag_x),
    .den_i({1'b0, cell_width_r}),
    .side_i(sneg_x), .vld_o(), .quo_o(gxq), .side_o(gneg_x)
  );
  lwg_div #(.DW(32), .QW(QB), .SW(1)) u_div_gy (
    .clk, .rst_n, .en, .vld_i(vld_a), .num_i(smag_y),
    .den_i({1'b0, cell_width_r}),
    .side_i(sneg_y), .vld_o(), .quo_o(gyq), .side_o(gneg_y)
  );

  // signed slopes, |G| < 1.0
  logic signed [GW-1:0] gx_b, gy_b;
  logic [GW-1:0]        gmag_x, gmag_y;

  always_comb begin
    gmag_x = {1'b0, gxq[FRAC_BITS:0]};
    gmag_y = {1'b0, gyq[FRAC_BITS:0]};
    gx_b   = gneg_x ? (GW'(0) - gmag_x) : gmag_x;
    gy_b   = gneg_y ? (GW'(0) - gmag_y) : gmag_y;
  end

  // normalized integrals fx = Ix/(2hl), fy = Iy/(2hl)
  logic                 vld_c, err_c;
  logic [QC-1:0]        fxq, fyq;
  logic signed [GW-1:0] gx_c, gy_c;
  logic [HALF_W-1:0]    hl_c;

  lwg_div #(.DW(32), .QW(QC), .SW(1 + GW)) u_div_fx (
    .clk, .rst_n, .en, .vld_i(vld_b),
    .num_i((32 + QC)'({ixq, {FRAC_BITS{1'b0}}})), .den_i({hl_b, 1'b0}),
    .side_i({err_b, gx_b}), .vld_o(vld_c), .quo_o(fxq), .side_o({err_c, gx_c})
  );
  lwg_div #(.DW(32), .QW(QC), .SW(GW + HALF_W)) u_div_fy (
    .clk, .rst_n, .en, .vld_i(vld_b),
    .num_i((32 + QC)'({iyq, {FRAC_BITS{1'b0}}})), .den_i({hl_b, 1'b0}),
    .side_i({gy_b, hl_b}), .vld_o(), .quo_o(fyq), .side_o({gy_c, hl_c})
  );

  // products for weight and gradient numerators
  logic                 vld_d_r, err_d_r;
  logic signed [PW-1:0] pgx_d_r, pgy_d_r;
  logic [WPW-1:0]       pw_d_r;
  logic [HALF_W-1:0]    hl_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pgx_d_r <= $signed({1'b0, fyq}) * gx_c;
      pgy_d_r <= $signed({1'b0, fxq}) * gy_c;
      pw_d_r  <= WPW'(fxq) * WPW'(fyq);
      err_d_r <= err_c;
      hl_d_r  <= hl_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_d_r <= vld_c;
    end
  end

  logic [PW-1:0] mag_gx, mag_gy;
  assign mag_gx = pgx_d_r[PW-1] ? (PW'(0) - pgx_d_r) : pgx_d_r;
  assign mag_gy = pgy_d_r[PW-1] ? (PW'(0) - pgy_d_r) : pgy_d_r;

  // gradients divided by 2hl, truncated toward zero on magnitudes
  logic           vld_e, err_e, neg_x_e, neg_y_e;
  logic [QD-1:0]  gxd, gyd;
  logic [WPW-1:0] pw_e;

  lwg_div #(.DW(32), .QW(QD), .SW(2 + WPW)) u_div_grx (
    .clk, .rst_n, .en, .vld_i(vld_d_r),
    .num_i((32 + QD)'(mag_gx[QD-1:0])), .den_i({hl_d_r, 1'b0}),
    .side_i({err_d_r, pgx_d_r[PW-1], pw_d_r}),
    .vld_o(vld_e), .quo_o(gxd), .side_o({err_e, neg_x_e, pw_e})
  );
  lwg_div #(.DW(32), .QW(QD), .SW(1)) u_div_gry (
    .clk, .rst_n, .en, .vld_i(vld_d_r),
    .num_i((32 + QD)'(mag_gy[QD-1:0])), .den_i({hl_d_r, 1'b0}),
    .side_i(pgy_d_r[PW-1]),
    .vld_o(), .quo_o(gyd), .side_o(neg_y_e)
  );

  // final saturation and range-error masking
  result_t        res;
  logic [EW-1:0]  gxe, gye;
  logic [WPW-1:0] ws;

  always_comb begin
    gxe = EW'(gxd);
    gye = EW'(gyd);
    ws  = pw_e >> FRAC_BITS;
    if (ws > (WPW'(1) << FRAC_BITS)) begin
      ws = WPW'(1) << FRAC_BITS;
    end
    if (ws > WPW'(17'h1FFFF)) begin
      ws = WPW'(17'h1FFFF);
    end
    res.weight = ws[WEIGHT_W-1:0];
    if (!neg_x_e) begin
      res.grad_x = (gxe > EW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : gxe[31:0];
    end else begin
      res.grad_x = (gxe > EW'(33'h080000000)) ? 32'h80000000 : (32'd0 - gxe[31:0]);
    end
    if (!neg_y_e) begin
      res.grad_y = (gye > EW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : gye[31:0];
    end else begin
      res.grad_y = (gye > EW'(33'h080000000)) ? 32'h80000000 : (32'd0 - gye[31:0]);
    end
    res.range_error = err_e;
    if (err_e) begin
      res.weight = '0;
      res.grad_x = '0;
      res.grad_y = '0;
    end
  end

  // output buffer: push from the last stage, pop on the result handshake
  logic push, pop;
  assign push = en & vld_e;
  assign pop  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  result_t head;
  assign head             = buf_mem[rd_ptr_r];
  assign out_valid        = (cnt_r != 2'd0);
  assign out_weight_value = head.weight;
  assign out_grad_x       = head.grad_x;
  assign out_grad_y       = head.grad_y;
  assign out_range_error  = head.range_error;

  // buffer never overfills
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");

  // a full buffer that is not drained keeps the pipeline held
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !out_ready) |=> (cnt_r == 2'd2 && !in_ready))
    else $error("pipeline advanced while output buffer full");

  // a flagged result carries no weight or gradient
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (out_weight_value == '0 && out_grad_x == '0 && out_grad_y == '0))
    else $error("range error result with nonzero payload");

  // nothing leaves the pipeline unless the buffer had room
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2))
    else $error("push into full output buffer");

endmodule
